// ----- rtl/clc_pkg.sv -----
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types, character codes and helpers for the coordinate line checker.
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int unsigned MAG_W  = 32;
  localparam int unsigned PROD_W = MAG_W + 4;

  localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(64'h8000_0000);

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  typedef enum logic [2:0] {
    P_SKIP   = 3'b001,
    P_DIGITS = 3'b010,
    P_DONE   = 3'b100
  } parse_state_t;

  typedef enum logic [2:0] {
    PRE_SKIP  = 3'b001,
    PRE_TOKEN = 3'b010,
    PRE_READY = 3'b100
  } pre_state_t;

  typedef struct packed {
    logic step;
    logic clear;
  } parse_ctrl_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [MAG_W-1:0] signed_out(input logic [MAG_W-1:0] mag,
                                                  input logic neg);
    return neg ? (~mag + MAG_W'(1)) : mag;
  endfunction

endpackage

// ----- rtl/clc_in_if.sv -----
// ----------------------------------------------------------------------------
// clc_in_if
// Byte stream channel: valid/ready handshake carrying one character.
// ----------------------------------------------------------------------------
interface clc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

// ----- rtl/clc_out_if.sv -----
// ----------------------------------------------------------------------------
// clc_out_if
// Result channel: valid/ready handshake carrying the line check outcome.
// ----------------------------------------------------------------------------
interface clc_out_if;
  logic               valid;
  logic               ready;
  logic               line_ok;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;

  modport source (output valid, output line_ok, output x_value, output y_value,
                  input ready);
  modport sink (input valid, input line_ok, input x_value, input y_value,
                output ready);
endinterface

// ----- rtl/clc_int_parser.sv -----
// ----------------------------------------------------------------------------
// clc_int_parser
// Decimal integer tracker: skips whitespace, optional sign, then digits.
// ----------------------------------------------------------------------------
module clc_int_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  clc_pkg::parse_ctrl_t         ctrl,
  input  logic [7:0]                   ch,
  output logic [clc_pkg::MAG_W-1:0]    magnitude,
  output logic                         negative,
  output logic                         overflow
);

  clc_pkg::parse_state_t          state;
  clc_pkg::parse_state_t          state_next;
  logic [clc_pkg::MAG_W-1:0]      magnitude_next;
  logic                           negative_next;
  logic [clc_pkg::PROD_W-1:0]     wide;
  logic [clc_pkg::PROD_W-1:0]     prod;
  logic                           over;
  logic                           take_digit;

  assign wide = clc_pkg::PROD_W'(magnitude);
  assign prod = (wide << 3) + (wide << 1) + clc_pkg::PROD_W'(ch[3:0]);
  assign over = negative ? (prod > clc_pkg::MAG_LIMIT) : (prod >= clc_pkg::MAG_LIMIT);
  assign take_digit = clc_pkg::is_digit(ch) && state != clc_pkg::P_DONE;
  assign overflow = ctrl.step && take_digit && over;

  always_comb begin
    state_next     = state;
    magnitude_next = magnitude;
    negative_next  = negative;
    if (take_digit && !over) begin
      magnitude_next = prod[clc_pkg::MAG_W-1:0];
    end
    unique case (state)
      clc_pkg::P_SKIP: begin
        if (clc_pkg::is_ws(ch)) begin
          state_next = clc_pkg::P_SKIP;
        end else if (ch == clc_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          state_next    = clc_pkg::P_DIGITS;
        end else if (ch == clc_pkg::CH_PLUS || clc_pkg::is_digit(ch)) begin
          state_next = clc_pkg::P_DIGITS;
        end else begin
          state_next = clc_pkg::P_DONE;
        end
      end
      clc_pkg::P_DIGITS: begin
        if (!clc_pkg::is_digit(ch)) begin
          state_next = clc_pkg::P_DONE;
        end
      end
      clc_pkg::P_DONE: begin
        state_next = clc_pkg::P_DONE;
      end
      default: begin
        state_next = clc_pkg::P_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      state     <= clc_pkg::P_SKIP;
      magnitude <= '0;
      negative  <= 1'b0;
    end else if (ctrl.step) begin
      state     <= state_next;
      magnitude <= magnitude_next;
      negative  <= negative_next;
    end
  end

endmodule

// ----- rtl/coordinate_line_checker_unit.sv -----
// ----------------------------------------------------------------------------
// coordinate_line_checker_unit
// Checks text lines of the form "name x y" and returns both coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   chars  : byte stream, one character per request; a zero byte ends a line.
//   result : one request per line, issued for each zero byte: line_ok and the
//            two parsed signed values (both 0 when the line has an error).
// Throughput: one byte per cycle while chars.ready is high. Every byte is
//   processed in the cycle it is accepted; the result appears in the cycle after the zero byte is accepted.
// The result register is the only buffer: while a result waits, further
//   bytes are still accepted if the receiver takes it in the same cycle;
//   otherwise chars.ready drops until result.ready is high.
// Reset (rst, synchronous) clears the line state and empties the result
//   register; the block then waits for the first byte of a new line.
// After each zero byte the line state returns to its reset value.
// ----------------------------------------------------------------------------
module coordinate_line_checker_unit (
  input logic     clk,
  input logic     rst,
  clc_in_if.sink  chars,
  clc_out_if.source result
);

  logic                        accept;
  logic                        end_of_line;
  logic                        step_active;
  logic                        in_name;
  logic                        seen_nonspace;
  logic                        error_seen;
  logic                        error_next;
  logic                        name_error;
  clc_pkg::pre_state_t         pre_state;
  clc_pkg::pre_state_t         pre_state_next;
  clc_pkg::parse_ctrl_t        ctrl_x;
  clc_pkg::parse_ctrl_t        ctrl_y;
  logic [clc_pkg::MAG_W-1:0]   mag_x;
  logic [clc_pkg::MAG_W-1:0]   mag_y;
  logic                        neg_x;
  logic                        neg_y;
  logic                        ovf_x;
  logic                        ovf_y;

  assign chars.ready  = !result.valid || result.ready;
  assign accept       = chars.valid && chars.ready;
  assign end_of_line  = accept && chars.ch == clc_pkg::CH_NUL;
  assign step_active  = accept && chars.ch != clc_pkg::CH_NUL && !error_seen;

  assign ctrl_x.step  = step_active && !in_name;
  assign ctrl_x.clear = end_of_line;
  assign ctrl_y.step  = step_active && !in_name && pre_state == clc_pkg::PRE_READY;
  assign ctrl_y.clear = end_of_line;

  assign name_error = step_active && in_name && chars.ch == clc_pkg::CH_MINUS;
  assign error_next = error_seen || name_error || ovf_x || ovf_y;

  clc_int_parser u_parse_x (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl_x),
    .ch        (chars.ch),
    .magnitude (mag_x),
    .negative  (neg_x),
    .overflow  (ovf_x)
  );

  clc_int_parser u_parse_y (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl_y),
    .ch        (chars.ch),
    .magnitude (mag_y),
    .negative  (neg_y),
    .overflow  (ovf_y)
  );

  // token skipper ahead of the second integer
  always_comb begin
    pre_state_next = pre_state;
    unique case (pre_state)
      clc_pkg::PRE_SKIP: begin
        if (chars.ch != clc_pkg::CH_SPACE) begin
          pre_state_next = clc_pkg::PRE_TOKEN;
        end
      end
      clc_pkg::PRE_TOKEN: begin
        if (chars.ch == clc_pkg::CH_SPACE) begin
          pre_state_next = clc_pkg::PRE_READY;
        end
      end
      clc_pkg::PRE_READY: begin
        pre_state_next = clc_pkg::PRE_READY;
      end
      default: begin
        pre_state_next = clc_pkg::PRE_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || end_of_line) begin
      in_name       <= 1'b1;
      seen_nonspace <= 1'b0;
      pre_state     <= clc_pkg::PRE_SKIP;
      error_seen    <= 1'b0;
    end else if (step_active) begin
      error_seen <= error_next;
      if (in_name) begin
        if (chars.ch != clc_pkg::CH_SPACE) begin
          seen_nonspace <= 1'b1;
        end
        if (chars.ch == clc_pkg::CH_SPACE && seen_nonspace) begin
          in_name <= 1'b0;
        end
      end else begin
        pre_state <= pre_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (end_of_line) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_of_line) begin
      result.line_ok <= !error_seen;
      result.x_value <= error_seen ? '0 : clc_pkg::signed_out(mag_x, neg_x);
      result.y_value <= error_seen ? '0 : clc_pkg::signed_out(mag_y, neg_y);
    end
  end

endmodule

// ----- rtl/clc_checker.sv -----
// ----------------------------------------------------------------------------
// clc_checker
// Port-level checks for the coordinate line checker, bound to the top level.
// ----------------------------------------------------------------------------
module clc_checker (
  input logic        clk,
  input logic        rst,
  input logic        chars_valid,
  input logic        chars_ready,
  input logic [7:0]  chars_ch,
  input logic        result_valid,
  input logic        result_ready,
  input logic        result_line_ok,
  input logic [31:0] result_x_value,
  input logic [31:0] result_y_value
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(result_line_ok) && $stable(result_x_value) && $stable(result_y_value))
    else $error("result payload changed while stalled");

  a_eol_result: assert property (@(posedge clk) disable iff (rst)
    chars_valid && chars_ready && chars_ch == 8'd0 |=> result_valid)
    else $error("no result after end of line");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    chars_valid && chars_ready && chars_ch != 8'd0 && (!result_valid || result_ready)
      |=> !result_valid)
    else $error("result without end of line");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_line_ok |-> result_x_value == 32'd0 && result_y_value == 32'd0)
    else $error("nonzero values on failed line");

endmodule

bind coordinate_line_checker_unit clc_checker u_clc_checker (
  .clk            (clk),
  .rst            (rst),
  .chars_valid    (chars.valid),
  .chars_ready    (chars.ready),
  .chars_ch       (chars.ch),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_line_ok (result.line_ok),
  .result_x_value (result.x_value),
  .result_y_value (result.y_value)
);
